FILE: sv/htmd_pkg.sv
`timescale 1ns / 1ps

package htmd_pkg;

  // access kinds
  localparam logic KIND_READ  = 1'b0;
  localparam logic KIND_WRITE = 1'b1;

  // register index carried by paddr[3]
  localparam logic REG_OUTBOUND_BASE = 1'b0;

  // device and command codes of the outbound word
  localparam logic [7:0] DEV_SYSCALL = 8'd0;
  localparam logic [7:0] CMD_EXIT    = 8'd0;
  localparam logic [7:0] DEV_CONSOLE = 8'd1;
  localparam logic [7:0] CMD_PUTCHAR = 8'd1;

  localparam logic signed [31:0] ERROR_STATUS = 32'sd1;

  typedef struct packed {
    logic        kind;
    logic [63:0] address;
    logic [3:0]  access_bytes;
    logic [63:0] write_data;
  } item_t;

  typedef struct packed {
    logic [63:0]        read_data;
    logic               console_valid;
    logic [7:0]         console_char;
    logic               exit_event;
    logic signed [31:0] exit_status;
    logic               command_error;
  } result_t;

  typedef struct packed {
    logic [63:0] outbound_word;
    logic [63:0] inbound_word;
    logic        halted_flag;
  } mbox_state_t;

endpackage

FILE: sv/htmd_exec.sv
`timescale 1ns / 1ps

module htmd_exec (
  input  htmd_pkg::item_t       item,
  input  logic [63:0]           outbound_base,
  input  htmd_pkg::mbox_state_t state,
  output htmd_pkg::result_t     result,
  output htmd_pkg::mbox_state_t state_next
);

  logic [2:0]  lane;
  logic [5:0]  shamt;
  logic [7:0]  byte_en;
  logic [63:0] mask;
  logic [63:0] base_diff;
  logic        is_out;
  logic [63:0] sel_word;
  logic [63:0] wr_bits;
  logic [63:0] out_merged;
  logic [63:0] in_merged;
  logic [7:0]  dev;
  logic [7:0]  cmd;
  logic [47:0] payload;
  logic        is_exit;
  logic        is_putchar;
  logic        halted_new;

  assign lane      = item.address[2:0];
  assign shamt     = {lane, 3'b000};
  assign base_diff = item.address - outbound_base;
  assign is_out    = (base_diff[63:3] == 61'd0);

  // byte lanes touched, clipped at lane 7
  always_comb begin
    for (int b = 0; b < 8; b++) begin
      logic [3:0] rel;
      rel = 4'(b) - {1'b0, lane};
      byte_en[b] = (3'(b) >= lane) && (rel < item.access_bytes);
    end
  end

  always_comb begin
    for (int b = 0; b < 8; b++) begin
      mask[8*b +: 8] = {8{byte_en[b]}};
    end
  end

  assign sel_word   = is_out ? state.outbound_word : state.inbound_word;
  assign wr_bits    = (item.write_data << shamt) & mask;
  assign out_merged = (state.outbound_word & ~mask) | wr_bits;
  assign in_merged  = (state.inbound_word & ~mask) | wr_bits;

  assign dev        = out_merged[63:56];
  assign cmd        = out_merged[55:48];
  assign payload    = out_merged[47:0];
  assign is_exit    = (dev == htmd_pkg::DEV_SYSCALL) && (cmd == htmd_pkg::CMD_EXIT);
  assign is_putchar = (dev == htmd_pkg::DEV_CONSOLE) && (cmd == htmd_pkg::CMD_PUTCHAR);

  always_comb begin
    result     = '0;
    state_next = state;
    halted_new = state.halted_flag;
    if (item.kind == htmd_pkg::KIND_READ) begin
      result.read_data = (sel_word & mask) >> shamt;
    end else if (!is_out) begin
      state_next.inbound_word = in_merged;
    end else begin
      state_next.outbound_word = out_merged;
      if (out_merged != 64'd0) begin
        if (is_putchar) begin
          result.console_valid = 1'b1;
          result.console_char  = payload[7:0];
        end else begin
          // exit, good or bad, or an unsupported command
          result.exit_event = 1'b1;
          halted_new        = 1'b1;
          if (is_exit && payload[0]) begin
            result.exit_status = payload[32:1];
          end else begin
            result.exit_status   = htmd_pkg::ERROR_STATUS;
            result.command_error = 1'b1;
          end
        end
        state_next.outbound_word = 64'd0;
        state_next.halted_flag   = halted_new;
        if (!halted_new) begin
          state_next.inbound_word = {dev, cmd, 48'd0};
        end
      end
    end
  end

endmodule

FILE: sv/host_target_mailbox_device.sv
`timescale 1ns / 1ps

// channel   | handshake            | payload
// ----------+----------------------+------------------------------------------------
// request   | req_valid, req_stall | kind, address, access_bytes, write_data
// response  | rsp_valid, rsp_stall | read_data, console_valid, console_char,
//           |                      | exit_event, exit_status, command_error
// config    | apb psel/penable     | paddr[3:0], pwdata/prdata 64 bits
//
// one item per cycle sustained while rsp_stall is low; an accepted item is captured
// in the request register, is executed against the mailbox state on its way to
// the response register and shows on the response port from there
// rst (synchronous) clears the mailbox words, the halt flag, outbound_base and
// both valid bits
// rsp_stall holds the response register; req_stall rises only when both stages are full

module host_target_mailbox_device (
  input  logic               clk,
  input  logic               rst,
  // config port
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [63:0]        pwdata,
  output logic [63:0]        prdata,
  output logic               pready,
  // request channel
  input  logic               req_valid,
  output logic               req_stall,
  input  logic               kind,
  input  logic [63:0]        address,
  input  logic [3:0]         access_bytes,
  input  logic [63:0]        write_data,
  // response channel
  output logic               rsp_valid,
  input  logic               rsp_stall,
  output logic [63:0]        read_data,
  output logic               console_valid,
  output logic [7:0]         console_char,
  output logic               exit_event,
  output logic signed [31:0] exit_status,
  output logic               command_error
);

  logic [63:0]           outbound_base;
  htmd_pkg::mbox_state_t state;
  htmd_pkg::mbox_state_t state_next;

  logic                  item_valid;
  htmd_pkg::item_t       item;
  htmd_pkg::result_t     result_next;
  htmd_pkg::result_t     result;

  logic                  advance;
  logic                  cfg_write;

  // apb: zero wait states, one 64-bit register at byte 0
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite
                     && (paddr[3] == htmd_pkg::REG_OUTBOUND_BASE);
  assign prdata    = (paddr[3] == htmd_pkg::REG_OUTBOUND_BASE) ? outbound_base : 64'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      outbound_base <= 64'd0;
    end else if (cfg_write) begin
      outbound_base <= pwdata;
    end
  end

  // the request register drains when the response register is free or taken
  assign advance   = !rsp_valid || !rsp_stall;
  assign req_stall = item_valid && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (!req_stall) begin
      item_valid <= req_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req_valid && !req_stall) begin
      item.kind         <= kind;
      item.address      <= address;
      item.access_bytes <= access_bytes;
      item.write_data   <= write_data;
    end
  end

  htmd_exec u_exec (
    .item          (item),
    .outbound_base (outbound_base),
    .state         (state),
    .result        (result_next),
    .state_next    (state_next)
  );

  // mailbox state commits as the item leaves for the response register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '0;
    end else if (item_valid && advance) begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (advance) begin
      rsp_valid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item_valid && advance) begin
      result <= result_next;
    end
  end

  assign read_data     = result.read_data;
  assign console_valid = result.console_valid;
  assign console_char  = result.console_char;
  assign exit_event    = result.exit_event;
  assign exit_status   = result.exit_status;
  assign command_error = result.command_error;

endmodule

FILE: bench/tb_host_target_mailbox_device.sv
`timescale 1ns / 1ps

import htmd_pkg::*;

// mirror of the mailbox: tracks both words, the halt flag and the base address,
// and queues the response owed for every accepted access
class mailbox_checker;
  logic [63:0] base_addr;
  logic [63:0] outbound;
  logic [63:0] inbound;
  logic        halted;
  result_t     expected_responses[$];
  int          errors;

  function new();
    base_addr = '0;
    outbound  = '0;
    inbound   = '0;
    halted    = 1'b0;
    errors    = 0;
  endfunction

  function int pending();
    return expected_responses.size();
  endfunction

  function void note_access(item_t a);
    result_t     r;
    logic [63:0] mask;
    logic [63:0] merged;
    logic [63:0] offset;
    logic [7:0]  dev;
    logic [7:0]  cmd;
    logic [47:0] payload;
    logic        hit;
    int          lane;
    int          nbytes;
    r      = '0;
    lane   = int'(a.address[2:0]);
    nbytes = (int'(a.access_bytes) < 8 - lane) ? int'(a.access_bytes) : 8 - lane;
    if (nbytes == 0) mask = '0;
    else if (nbytes == 8) mask = '1;
    else mask = (64'd1 << (8 * nbytes)) - 64'd1;
    mask   = mask << (8 * lane);
    offset = a.address - base_addr;
    hit    = offset < 64'd8;
    if (a.kind == KIND_READ) begin
      r.read_data = ((hit ? outbound : inbound) & mask) >> (8 * lane);
    end else if (!hit) begin
      inbound = (inbound & ~mask) | ((a.write_data << (8 * lane)) & mask);
    end else begin
      merged   = (outbound & ~mask) | ((a.write_data << (8 * lane)) & mask);
      outbound = merged;
      if (merged != '0) begin
        dev     = merged[63:56];
        cmd     = merged[55:48];
        payload = merged[47:0];
        if (dev == DEV_SYSCALL && cmd == CMD_EXIT) begin
          r.exit_event = 1'b1;
          halted       = 1'b1;
          if (payload[0]) begin
            r.exit_status = payload[32:1];
          end else begin
            r.exit_status   = ERROR_STATUS;
            r.command_error = 1'b1;
          end
        end else if (dev == DEV_CONSOLE && cmd == CMD_PUTCHAR) begin
          r.console_valid = 1'b1;
          r.console_char  = payload[7:0];
        end else begin
          r.exit_event    = 1'b1;
          r.exit_status   = ERROR_STATUS;
          r.command_error = 1'b1;
          halted          = 1'b1;
        end
        outbound = '0;
        if (!halted) inbound = {dev, cmd, 48'd0};
      end
    end
    expected_responses.push_back(r);
  endfunction

  function void check_response(result_t got);
    result_t want;
    if (expected_responses.size() == 0) begin
      $error("response with nothing outstanding: read_data %h", got.read_data);
      errors++;
      return;
    end
    want = expected_responses.pop_front();
    if (got.read_data !== want.read_data) begin
      $error("read_data: expected %h, got %h", want.read_data, got.read_data);
      errors++;
    end
    if (got.console_valid !== want.console_valid) begin
      $error("console_valid: expected %b, got %b", want.console_valid, got.console_valid);
      errors++;
    end
    if (got.console_char !== want.console_char) begin
      $error("console_char: expected %h, got %h", want.console_char, got.console_char);
      errors++;
    end
    if (got.exit_event !== want.exit_event) begin
      $error("exit_event: expected %b, got %b", want.exit_event, got.exit_event);
      errors++;
    end
    if (got.exit_status !== want.exit_status) begin
      $error("exit_status: expected %0d, got %0d", want.exit_status, got.exit_status);
      errors++;
    end
    if (got.command_error !== want.command_error) begin
      $error("command_error: expected %b, got %b", want.command_error, got.command_error);
      errors++;
    end
  endfunction
endclass

module tb_host_target_mailbox_device;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [3:0]         paddr = '0;
  logic [63:0]        pwdata = '0;
  logic [63:0]        prdata;
  logic               pready;
  logic               req_valid = 1'b0;
  logic               req_stall;
  logic               kind = KIND_READ;
  logic [63:0]        address = '0;
  logic [3:0]         access_bytes = '0;
  logic [63:0]        write_data = '0;
  logic               rsp_valid;
  logic               rsp_stall = 1'b0;
  logic [63:0]        read_data;
  logic               console_valid;
  logic [7:0]         console_char;
  logic               exit_event;
  logic signed [31:0] exit_status;
  logic               command_error;

  mailbox_checker sb = new();

  // sender burst bookkeeping: items left in the current burst
  int burst_left = 0;

  host_target_mailbox_device i_dut (
    .clk           (clk),
    .rst           (rst),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .req_valid     (req_valid),
    .req_stall     (req_stall),
    .kind          (kind),
    .address       (address),
    .access_bytes  (access_bytes),
    .write_data    (write_data),
    .rsp_valid     (rsp_valid),
    .rsp_stall     (rsp_stall),
    .read_data     (read_data),
    .console_valid (console_valid),
    .console_char  (console_char),
    .exit_event    (exit_event),
    .exit_status   (exit_status),
    .command_error (command_error)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // hard stop in case the block wedges
  initial begin
    #400000;
    $display("Some tests failed");
    $finish;
  end

  // offer one item and hold it until the block takes it; between bursts the
  // request line drops for a random gap, some bursts are long enough to keep
  // the pipe full for a while
  task automatic offer(item_t a);
    int gap;
    req_valid    <= 1'b1;
    kind         <= a.kind;
    address      <= a.address;
    access_bytes <= a.access_bytes;
    write_data   <= a.write_data;
    do @(posedge clk); while (req_stall);
    sb.note_access(a);
    if (burst_left == 0) begin
      req_valid <= 1'b0;
      gap = $urandom_range(1, 8);
      repeat (gap) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 12);
    end else begin
      burst_left--;
    end
  endtask

  task automatic access(logic k, logic [63:0] addr, logic [3:0] size, logic [63:0] data);
    item_t a;
    a.kind         = k;
    a.address      = addr;
    a.access_bytes = size;
    a.write_data   = data;
    offer(a);
  endtask

  // drain everything in flight so the block is idle
  task automatic settle();
    req_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // apb write of the outbound base: setup cycle, then access until pready
  task automatic set_outbound_base(logic [63:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {REG_OUTBOUND_BASE, 3'b000};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    sb.base_addr = value;
  endtask

  // random bus traffic; without exits the outbound word only ever sees clean
  // putchar commands or zero data, so the mailbox keeps acking
  function automatic item_t random_access(logic [63:0] base, bit allow_exit);
    item_t       a;
    int          r;
    int          pick;
    logic [7:0]  dev;
    logic [7:0]  cmd;
    logic [47:0] payload;
    a.kind         = KIND_READ;
    a.address      = {$urandom, $urandom};
    a.access_bytes = ($urandom_range(0, 9) < 6) ? (4'd1 << $urandom_range(0, 3))
                                               : 4'($urandom_range(0, 15));
    a.write_data   = {$urandom, $urandom};
    r = $urandom_range(0, 99);
    if (r < 20) begin
      // reads, mostly of the outbound word or just around it
      pick = $urandom_range(0, 3);
      case (pick)
        0: a.address = base + 64'($urandom_range(0, 7));
        1: a.address = base + 64'd8;
        2: a.address = base - 64'd1;
        default: ;
      endcase
    end else if (r < 38) begin
      // inbound writes, near the mailbox or anywhere
      a.kind = KIND_WRITE;
      if ($urandom_range(0, 1) == 0) a.address = base + 64'($urandom_range(8, 71));
      if ((a.address - base) < 64'd8) a.address = base + 64'd8;
    end else if (r < 72) begin
      // whole-word command written at the base
      a.kind         = KIND_WRITE;
      a.address      = base;
      a.access_bytes = 4'd8;
      payload        = {$urandom, $urandom};
      pick           = allow_exit ? $urandom_range(0, 99) : 0;
      if (pick < 60) begin
        dev = DEV_CONSOLE;
        cmd = CMD_PUTCHAR;
      end else if (pick < 85) begin
        dev        = DEV_SYSCALL;
        cmd        = CMD_EXIT;
        payload[0] = (pick < 75);
      end else begin
        dev = 8'($urandom);
        cmd = 8'($urandom);
      end
      a.write_data = {dev, cmd, payload};
    end else if (r < 85) begin
      // partial outbound writes
      a.kind    = KIND_WRITE;
      a.address = base + 64'($urandom_range(0, 7));
      if (!allow_exit) begin
        if ($urandom_range(0, 1) == 0) begin
          a.write_data = '0;
        end else begin
          // top half only: putchar of a zero char
          a.address      = base + 64'd6;
          a.access_bytes = 4'd2;
          a.write_data   = {48'($urandom), DEV_CONSOLE, CMD_PUTCHAR};
        end
      end
    end else begin
      // noise
      a.kind = logic'($urandom_range(0, 1));
      a.access_bytes = 4'($urandom_range(0, 15));
      if (!allow_exit && a.kind == KIND_WRITE && (a.address - base) < 64'd8)
        a.kind = KIND_READ;
    end
    return a;
  endfunction

  task automatic run_random(int count, bit allow_exit);
    repeat (count) offer(random_access(sb.base_addr, allow_exit));
  endtask

  // response side: checks every accepted result and stalls on its own
  // schedule, including two long hold-offs that back the block up
  initial begin
    int      mode;
    int      mode_left;
    int      hold_left;
    int      seen;
    logic    nxt;
    result_t got;
    mode      = 0;
    mode_left = 0;
    hold_left = 0;
    seen      = 0;
    forever begin
      @(posedge clk);
      if (!rst && rsp_valid && !rsp_stall) begin
        got.read_data     = read_data;
        got.console_valid = console_valid;
        got.console_char  = console_char;
        got.exit_event    = exit_event;
        got.exit_status   = exit_status;
        got.command_error = command_error;
        sb.check_response(got);
        seen++;
        if (seen == 150 || seen == 900) hold_left = 120;
      end
      if (hold_left > 0) begin
        nxt = 1'b1;
        hold_left--;
      end else begin
        if (mode_left == 0) begin
          mode      = $urandom_range(0, 3);
          mode_left = $urandom_range(20, 150);
        end
        mode_left--;
        case (mode)
          0: nxt = 1'b0;
          1: nxt = ($urandom_range(0, 3) == 0);
          2: nxt = ($urandom_range(0, 3) != 0);
          default: nxt = !rsp_stall;
        endcase
      end
      rsp_stall <= nxt;
    end
  end

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // byte lanes, sizes and acks with base at zero
    access(KIND_READ, 64'h100, 4'd8, '0);
    access(KIND_READ, 64'h0, 4'd8, '0);
    access(KIND_WRITE, 64'h10, 4'd8, '1);
    // read running past lane seven
    access(KIND_READ, 64'h13, 4'd8, '0);
    // zero-size read
    access(KIND_READ, 64'h10, 4'd0, '0);
    // oversize write clipped at lane seven
    access(KIND_WRITE, 64'h15, 4'd15, '0);
    // zero-size writes, inbound then outbound
    access(KIND_WRITE, 64'h10, 4'd0, '1);
    access(KIND_READ, 64'h10, 4'd8, '0);
    access(KIND_WRITE, 64'h0, 4'd0, '1);
    // putchar and its ack
    access(KIND_WRITE, 64'h0, 4'd8, {DEV_CONSOLE, CMD_PUTCHAR, 48'h41});
    access(KIND_READ, 64'h18, 4'd8, '0);
    access(KIND_WRITE, 64'h0, 4'd8, {DEV_CONSOLE, CMD_PUTCHAR, 48'hffff_ffff_ffff});
    // command assembled by a partial write of the top half
    access(KIND_WRITE, 64'h6, 4'd2, {48'd0, DEV_CONSOLE, CMD_PUTCHAR});
    access(KIND_WRITE, 64'h5, 4'd9, {40'd0, DEV_CONSOLE, CMD_PUTCHAR, 8'h00});
    access(KIND_READ, 64'h3, 4'd4, '0);
    access(KIND_READ, 64'hffff_ffff_ffff_ffff, 4'd1, '0);
    settle();

    // ack-only traffic at two aligned bases, top of the address space first
    set_outbound_base(64'hffff_ffff_ffff_fff8);
    run_random(300, 1'b0);
    settle();
    set_outbound_base({$urandom, $urandom} & ~64'd7);
    run_random(300, 1'b0);
    settle();

    // exits and halt behavior
    set_outbound_base(64'h0);
    // normal exit with the widest payload, status wraps negative
    access(KIND_WRITE, 64'h0, 4'd8, {DEV_SYSCALL, CMD_EXIT, 48'hffff_ffff_ffff});
    access(KIND_READ, 64'h8, 4'd8, '0);
    // putchar still emits after halt but leaves inbound alone
    access(KIND_WRITE, 64'h0, 4'd8, {DEV_CONSOLE, CMD_PUTCHAR, 48'h5a});
    access(KIND_READ, 64'h8, 4'd8, '0);
    // exit with an even payload is a bad syscall
    access(KIND_WRITE, 64'h0, 4'd8, {DEV_SYSCALL, CMD_EXIT, 48'h2});
    // unsupported device and command
    access(KIND_WRITE, 64'h0, 4'd8, {8'hff, 8'hff, 48'h0});
    access(KIND_WRITE, 64'h0, 4'd8, {DEV_SYSCALL, CMD_EXIT, 48'h1});
    // single byte in lane seven makes device 1, command 0
    access(KIND_WRITE, 64'h7, 4'd1, {56'd0, DEV_CONSOLE});
    access(KIND_READ, 64'h0, 4'd8, '0);
    settle();

    // everything goes, including unaligned and wrapping bases
    set_outbound_base('1);
    run_random(350, 1'b1);
    settle();
    set_outbound_base({$urandom, $urandom} | 64'd1);
    run_random(350, 1'b1);
    settle();
    set_outbound_base(64'h8);
    run_random(350, 1'b1);
    settle();

    repeat (10) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
